### src/crc_checked_segment_reader_macros.svh
// assertion macros for the crc checked segment reader
// used by the top level only; expects clk and rst_n in scope
`ifndef CRC_CHECKED_SEGMENT_READER_MACROS_SVH
`define CRC_CHECKED_SEGMENT_READER_MACROS_SVH

// same-cycle implication, disabled during reset
`define CCSR_ASSERT_SAME(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("ccsr same-cycle check failed");

// next-cycle implication, disabled during reset
`define CCSR_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("ccsr next-cycle check failed");

`endif

### src/ccsr_pkg.sv
// shared types and constants for the crc checked segment reader
// no dependencies
`timescale 1ns / 1ps

package ccsr_pkg;

    typedef enum logic [1:0]
    {
        PH_PAYLOAD = 2'd0,
        PH_PAD     = 2'd1,
        PH_CRC     = 2'd2,
        PH_DONE    = 2'd3
    } phase_t;

    typedef logic [2:0] status_t;

    localparam status_t ST_BUSY   = 3'd0;
    localparam status_t ST_OK     = 3'd1;
    localparam status_t ST_BADPAD = 3'd2;
    localparam status_t ST_BADCRC = 3'd3;
    localparam status_t ST_TRUNC  = 3'd4;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [2:0]  CRC_BYTES = 3'd4;

    typedef struct packed
    {
        logic        done_res;
        status_t     status;
        logic        payload_valid;
        logic [7:0]  payload_byte;
    } result_t;

endpackage

### src/crc_checked_segment_reader.sv
// crc checked segment reader: one byte per item, crc-32 framed segment
// Channels: s_axis carries source bytes (tuser marks end of source), m_axis
// carries one result item per input item. cfg_we/cfg_data load the payload
// length and re-arm the check; write only while the block is idle.
// Frame: length payload bytes, zero padding to a multiple of four, then the
// crc-32 of payload and padding, most significant byte first.
// Flow: an accepted item waits in the input register, then moves to the
// result register that drives m_axis. Throughput is one item per cycle while
// m_axis is not stalled, set by the combinational crc byte update in the state
// loop between the input register and the result register.
// Payload bytes come out with tuser set; the final status is held and
// repeated for every later item until the next length write.
// Reset: the length is zero, the check is armed and both registers empty.
// When m_axis stalls the result register holds; the input register still
// takes one more item, then s_axis_tready drops until the result is taken.
// depends on ccsr_pkg, ccsr_check_core and the assertion macro header
`timescale 1ns / 1ps

`include "crc_checked_segment_reader_macros.svh"

module crc_checked_segment_reader #(
    parameter int LENGTH_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] source_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] status, [11] done_res
    output logic        m_axis_tuser,   // [0] payload_valid
    input  logic        cfg_we,
    input  logic [31:0] cfg_data
);
    import ccsr_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_result_reg;
    result_t    core_result;
    logic       accept;
    logic       advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    ccsr_check_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .data_byte  (in_byte_reg),
        .source_end (in_end_reg),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .result     (core_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= s_axis_tdata;
            in_end_reg  <= s_axis_tuser;
        end
        if (advance)
        begin
            out_result_reg <= core_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_result_reg.done_res, out_result_reg.status,
                            out_result_reg.payload_byte};
    assign m_axis_tuser  = out_result_reg.payload_valid;

    // a payload item is never a final one
    `CCSR_ASSERT_SAME(a_payload_busy, m_axis_tvalid && m_axis_tuser, m_axis_tdata[11:8] == 4'd0)
    // a finished check always carries a real status
    `CCSR_ASSERT_SAME(a_done_status, m_axis_tvalid && m_axis_tdata[11], m_axis_tdata[10:8] != ST_BUSY)
    // every item that leaves the input register lands in the result register
    `CCSR_ASSERT_NEXT(a_advance_lands, advance, out_valid_reg)

endmodule

### src/ccsr_crc_byte.sv
// one-byte update of the reflected crc-32
// depends on ccsr_pkg
`timescale 1ns / 1ps

module ccsr_crc_byte
(
    input  logic [31:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [31:0] crc_out
);
    import ccsr_pkg::*;

    always_comb
    begin
        logic [31:0] c;
        c = crc_in ^ {24'd0, data_in};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

### src/ccsr_check_core.sv
// segment check state machine: phases, counters, crc and final status
// depends on ccsr_pkg and ccsr_crc_byte
`timescale 1ns / 1ps

module ccsr_check_core #(
    parameter int LENGTH_BITS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              source_end,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_data,
    output ccsr_pkg::result_t result
);
    import ccsr_pkg::*;

    phase_t                 phase_reg, phase_next, phase_eff;
    logic [LENGTH_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [1:0]             pad_left_reg, pad_left_next;
    logic [31:0]            crc_running_reg, crc_running_next;
    logic [31:0]            crc_expected_reg, crc_expected_next;
    logic [2:0]             crc_seen_reg, crc_seen_next;
    status_t                final_status_reg, final_status_next;

    logic [LENGTH_BITS-1:0] cfg_len;
    logic [31:0]            crc_upd;
    logic [31:0]            crc_shift;
    logic [2:0]             seen_inc;

    assign cfg_len   = LENGTH_BITS'(cfg_data);
    assign crc_shift = {crc_expected_reg[23:0], data_byte};
    assign seen_inc  = crc_seen_reg + 3'd1;

    ccsr_crc_byte u_crc
    (
        .crc_in  (crc_running_reg),
        .data_in (data_byte),
        .crc_out (crc_upd)
    );

    // exhausted phases are skipped before the item is handled
    always_comb
    begin
        phase_eff = phase_reg;
        if (phase_eff == PH_PAYLOAD && bytes_left_reg == '0)
        begin
            phase_eff = PH_PAD;
        end
        if (phase_eff == PH_PAD && pad_left_reg == 2'd0)
        begin
            phase_eff = PH_CRC;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        bytes_left_next   = bytes_left_reg;
        pad_left_next     = pad_left_reg;
        crc_running_next  = crc_running_reg;
        crc_expected_next = crc_expected_reg;
        crc_seen_next     = crc_seen_reg;
        final_status_next = final_status_reg;
        if (cfg_we)
        begin
            phase_next        = PH_PAYLOAD;
            bytes_left_next   = cfg_len;
            pad_left_next     = 2'd0 - cfg_len[1:0];
            crc_running_next  = CRC_INIT;
            crc_expected_next = 32'd0;
            crc_seen_next     = 3'd0;
            final_status_next = ST_BUSY;
        end
        else if (step && phase_eff != PH_DONE)
        begin
            phase_next = phase_eff;
            if (source_end)
            begin
                phase_next        = PH_DONE;
                final_status_next = ST_TRUNC;
            end
            else
            begin
                case (phase_eff)
                    PH_PAYLOAD:
                    begin
                        crc_running_next = crc_upd;
                        bytes_left_next  = bytes_left_reg - LENGTH_BITS'(1);
                    end
                    PH_PAD:
                    begin
                        crc_running_next = crc_upd;
                        if (data_byte != 8'd0)
                        begin
                            phase_next        = PH_DONE;
                            final_status_next = ST_BADPAD;
                        end
                        else
                        begin
                            pad_left_next = pad_left_reg - 2'd1;
                        end
                    end
                    PH_CRC:
                    begin
                        crc_expected_next = crc_shift;
                        crc_seen_next     = seen_inc;
                        if (seen_inc >= CRC_BYTES)
                        begin
                            phase_next        = PH_DONE;
                            final_status_next = (crc_shift == ~crc_running_reg) ?
                                                ST_OK : ST_BADCRC;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        result.payload_valid = (phase_eff == PH_PAYLOAD) && !source_end;
        result.payload_byte  = result.payload_valid ? data_byte : 8'd0;
        result.done_res      = (phase_next == PH_DONE);
        result.status        = result.done_res ? final_status_next : ST_BUSY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_PAYLOAD;
            bytes_left_reg   <= '0;
            pad_left_reg     <= 2'd0;
            crc_running_reg  <= CRC_INIT;
            crc_expected_reg <= 32'd0;
            crc_seen_reg     <= 3'd0;
            final_status_reg <= ST_BUSY;
        end
        else
        begin
            phase_reg        <= phase_next;
            bytes_left_reg   <= bytes_left_next;
            pad_left_reg     <= pad_left_next;
            crc_running_reg  <= crc_running_next;
            crc_expected_reg <= crc_expected_next;
            crc_seen_reg     <= crc_seen_next;
            final_status_reg <= final_status_next;
        end
    end

endmodule

### tb/ccsr_frame_checker.sv
// result checker for the crc checked segment reader: watches both streams and the length port,
// predicts each result item from the accepted input items and compares them field by field
// depends on ccsr_pkg
`timescale 1ns / 1ps

module ccsr_frame_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          pending
);
    import ccsr_pkg::*;

    phase_t      ph;
    logic [31:0] bytes_left;
    logic [1:0]  pad_left;
    logic [31:0] crc_run;
    logic [31:0] crc_rx;
    logic [2:0]  crc_seen;
    status_t     fin_status;
    result_t     pending_verdicts[$];

    function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    task automatic rearm(input logic [31:0] len);
        bytes_left = len;
        pad_left   = 2'd0 - len[1:0];
        crc_run    = CRC_INIT;
        crc_rx     = 32'd0;
        crc_seen   = 3'd0;
        fin_status = ST_BUSY;
        ph         = PH_PAYLOAD;
    endtask

    task automatic track_frame(input logic [7:0] b, input logic src_end, output result_t r);
        r = '0;
        // exhausted phases hand the item on to the next one
        if (ph == PH_PAYLOAD && bytes_left == 32'd0)
            ph = PH_PAD;
        if (ph == PH_PAD && pad_left == 2'd0)
            ph = PH_CRC;
        if (ph != PH_DONE)
        begin
            if (src_end)
            begin
                fin_status = ST_TRUNC;
                ph = PH_DONE;
            end
            else if (ph == PH_PAYLOAD)
            begin
                crc_run = crc_update(crc_run, b);
                bytes_left = bytes_left - 32'd1;
                r.payload_byte = b;
                r.payload_valid = 1'b1;
            end
            else if (ph == PH_PAD)
            begin
                crc_run = crc_update(crc_run, b);
                if (b != 8'd0)
                begin
                    fin_status = ST_BADPAD;
                    ph = PH_DONE;
                end
                else
                    pad_left = pad_left - 2'd1;
            end
            else
            begin
                crc_rx = {crc_rx[23:0], b};
                crc_seen = crc_seen + 3'd1;
                if (crc_seen >= CRC_BYTES)
                begin
                    fin_status = (crc_rx == ~crc_run) ? ST_OK : ST_BADCRC;
                    ph = PH_DONE;
                end
            end
        end
        r.status = (ph == PH_DONE) ? fin_status : ST_BUSY;
        r.done_res = (ph == PH_DONE);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t got;
        result_t fresh;
        if (!rst_n)
        begin
            rearm(32'd0);
            pending_verdicts.delete();
            errors = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.payload_byte  = m_axis_tdata[7:0];
                got.status        = m_axis_tdata[10:8];
                got.done_res      = m_axis_tdata[11];
                got.payload_valid = m_axis_tuser;
                if (pending_verdicts.size() == 0)
                begin
                    $error("result item with nothing expected: tdata %0h tuser %0b",
                           m_axis_tdata, m_axis_tuser);
                    errors++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (got.payload_byte !== want.payload_byte)
                    begin
                        $error("payload_byte expected %0h got %0h",
                               want.payload_byte, got.payload_byte);
                        errors++;
                    end
                    if (got.payload_valid !== want.payload_valid)
                    begin
                        $error("payload_valid expected %0b got %0b",
                               want.payload_valid, got.payload_valid);
                        errors++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status expected %0d got %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.done_res !== want.done_res)
                    begin
                        $error("done_res expected %0b got %0b", want.done_res, got.done_res);
                        errors++;
                    end
                end
            end
            if (cfg_we)
                rearm(cfg_data);
            if (s_axis_tvalid && s_axis_tready)
            begin
                track_frame(s_axis_tdata, s_axis_tuser, fresh);
                pending_verdicts.push_back(fresh);
            end
        end
        pending = pending_verdicts.size();
    end

endmodule

### tb/tb_top.sv
// testbench top for the crc checked segment reader: drives framed segments with random
// payloads and faults, random stalls on both streams, and reports the verdict
// depends on ccsr_pkg, crc_checked_segment_reader and ccsr_frame_checker
`timescale 1ns / 1ps

module tb_top;
    import ccsr_pkg::*;

    localparam int ITEM_TARGET = 1800;
    localparam int QUIET_AFTER = 1500;
    localparam int CYCLE_LIMIT = 1000000;

    typedef enum int
    {
        FR_GOOD,
        FR_BADCRC,
        FR_BADPAD,
        FR_TRUNC
    } frame_kind_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_we;
    logic [31:0] cfg_data;

    int fail_count;
    int in_flight;
    int items_sent = 0;
    int gap_pct = 0;
    int cycles = 0;
    bit quiet = 1'b0;

    crc_checked_segment_reader u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data)
    );

    ccsr_frame_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .errors        (fail_count),
        .pending       (in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("crc_checked_segment_reader: mismatch");
            $finish;
        end
    end

    function automatic logic [31:0] frame_crc(input logic [7:0] bytes_in[$]);
        logic [31:0] c;
        c = CRC_INIT;
        foreach (bytes_in[k])
        begin
            c ^= {24'd0, bytes_in[k]};
            repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return ~c;
    endfunction

    task automatic put(input logic [7:0] b, input logic src_end);
        if (!quiet && $urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= src_end;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic program_length(input logic [31:0] len);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= len;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic run_frame(input logic [31:0] len, input frame_kind_t kind, input int fill,
                             input int extras);
        logic [7:0]  body[$];
        logic [31:0] crc;
        int          pad;
        int          idx;
        program_length(len);
        gap_pct = 25 * $urandom_range(0, 2);
        if (len > 32'd1024)
        begin
            // segment too long to finish, cut short by a source end
            repeat ($urandom_range(0, 8)) body.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            pad = (4 - int'(len[1:0])) % 4;
            for (int k = 0; k < int'(len); k++)
                body.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
            repeat (pad) body.push_back(8'd0);
            crc = frame_crc(body);
            body.push_back(crc[31:24]);
            body.push_back(crc[23:16]);
            body.push_back(crc[15:8]);
            body.push_back(crc[7:0]);
            case (kind)
                FR_BADCRC:
                begin
                    idx = body.size() - 1 - $urandom_range(0, 3);
                    body[idx] ^= 8'(1 << $urandom_range(0, 7));
                end
                FR_BADPAD:
                begin
                    idx = int'(len) + $urandom_range(0, pad - 1);
                    body[idx] = 8'($urandom_range(1, 255));
                    while (body.size() > idx + 1)
                        void'(body.pop_back());
                end
                FR_TRUNC:
                begin
                    idx = $urandom_range(0, body.size() - 1);
                    while (body.size() > idx)
                        void'(body.pop_back());
                end
                default:
                    ;
            endcase
        end
        foreach (body[k])
            put(body[k], 1'b0);
        if (kind == FR_TRUNC)
            put(8'($urandom_range(0, 255)), 1'b1);
        repeat (extras) put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // receiver: random stall bursts, plus a long hold-off now and then to back up the block
    initial
    begin : receiver
        int hold;
        int stall_pct;
        int cyc;
        hold = 0;
        stall_pct = 0;
        cyc = 0;
        m_axis_tready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 256 == 0)
                stall_pct = 25 * $urandom_range(0, 2);
            if (cyc % 2500 == 1200 && !quiet)
                hold = 300;
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < stall_pct)
            begin
                hold = $urandom_range(0, 15);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int          sel;
        logic [31:0] len;
        frame_kind_t kind;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        s_axis_tuser  <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_data      <= 32'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty payload straight to crc, then items after completion
        run_frame(32'd0, FR_GOOD, -1, 0);
        put(8'hA5, 1'b0);
        put(8'h3C, 1'b1);
        run_frame(32'd1, FR_GOOD, 255, 0);
        run_frame(32'd2, FR_BADPAD, 0, 0);
        run_frame(32'd0, FR_BADCRC, -1, 0);
        run_frame(32'd5, FR_TRUNC, -1, 0);
        run_frame(32'hFFFF_FFFF, FR_TRUNC, -1, 1);

        while (items_sent < ITEM_TARGET)
        begin
            quiet = (items_sent >= QUIET_AFTER);
            sel = $urandom_range(0, 99);
            if (sel < 70)
                len = $urandom_range(0, 12);
            else if (sel < 92)
                len = $urandom_range(13, 64);
            else
                len = $urandom();
            sel = $urandom_range(0, 99);
            kind = (sel < 60) ? FR_GOOD : (sel < 75) ? FR_BADCRC :
                   (sel < 85) ? FR_BADPAD : FR_TRUNC;
            if (len > 32'd1024)
                kind = FR_TRUNC;
            if (kind == FR_BADPAD && len[1:0] == 2'd0)
                kind = FR_GOOD;
            run_frame(len, kind, -1, $urandom_range(0, 2));
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("crc_checked_segment_reader: match");
        else
            $display("crc_checked_segment_reader: mismatch");
        $finish;
    end

endmodule
